// ----- sv/ucv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucv_pkg
// Shared constants and ASCII class helpers for the URI component validator:
// component type codes, register map, escape/octet limits, character codes.
// ----------------------------------------------------------------------------
package ucv_pkg;

  // component type codes held in the mode register
  localparam logic [3:0] MODE_SEGMENT  = 4'd0;
  localparam logic [3:0] MODE_PATH     = 4'd1;
  localparam logic [3:0] MODE_ABSOLUTE = 4'd2;
  localparam logic [3:0] MODE_ROOTLESS = 4'd3;
  localparam logic [3:0] MODE_ABEMPTY  = 4'd4;
  localparam logic [3:0] MODE_QUERY    = 4'd5;
  localparam logic [3:0] MODE_USERINFO = 4'd6;
  localparam logic [3:0] MODE_SCHEME   = 4'd7;
  localparam logic [3:0] MODE_IPV4     = 4'd8;

  // register map
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam logic        REG_MODE  = 1'b0;

  // escape and octet limits
  localparam logic [1:0] EscDigits = 2'd2;
  localparam logic [9:0] OctetMax  = 10'd255;
  localparam logic [2:0] OctetMaxDigits = 3'd3;
  localparam logic [2:0] Ipv4Dots  = 3'd3;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // unreserved: alpha, digit, "-._~"
  function automatic logic is_unreserved(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_DOT) ||
           (c == 8'h5F) || (c == 8'h7E);
  endfunction

  // sub-delims: "!$&'()*+,;="
  function automatic logic is_sub_delim(input logic [7:0] c);
    return (c == 8'h21) || (c == 8'h24) || (c == 8'h26) || (c == 8'h27) ||
           (c == 8'h28) || (c == 8'h29) || (c == 8'h2A) || (c == CH_PLUS) ||
           (c == 8'h2C) || (c == 8'h3B) || (c == 8'h3D);
  endfunction

endpackage

// ----- sv/uri_component_validator.sv -----
`timescale 1ns / 1ps
// Result path: the last byte of a string is transferred into the input
// register, then its verdict is written into the result register.
// Throughput: one byte per cycle unless a last byte meets a stalled result;
// per-string update: one short pass, input register to state/result regs.
// Reset: mode returns to segment, the string state clears, no result pending.
// ----------------------------------------------------------------------------
// uri_component_validator
// Checks a URI component, streamed at most one byte per transfer, against the
// component type in the mode register and returns one accept/reject result
// for each string.
// ----------------------------------------------------------------------------
module uri_component_validator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ucv_pkg::AddrWidth-1:0]     paddr,
  input  logic [ucv_pkg::DataWidth-1:0]     pwdata,
  output logic [ucv_pkg::DataWidth-1:0]     prdata,
  output logic                              pready,
  // byte stream in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        char_code_i,
  input  logic                              last_i,
  input  logic                              no_char_i,
  // result out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              accepted_o
);

  // configuration register
  logic [3:0] mode_q;
  logic       cfg_wr;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_no_char_q;
  logic       s1_adv;
  logic       proc;

  // string state
  logic [1:0] esc_q, esc_d;
  logic       start_q, start_d;
  logic       failed_q, failed_d;
  logic [2:0] dots_q, dots_d;
  logic [2:0] digits_q, digits_d;
  logic [9:0] value_q, value_d;
  logic       lzero_q, lzero_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       accepted_q, accepted_d;

  // plain byte allowed by the text modes
  function automatic logic text_ok(input logic [7:0] c, input logic [3:0] m);
    logic ok;
    if (ucv_pkg::is_unreserved(c) || ucv_pkg::is_sub_delim(c)) begin
      ok = 1'b1;
    end else if (m == ucv_pkg::MODE_USERINFO) begin
      ok = (c == ucv_pkg::CH_COLON);
    end else if ((c == ucv_pkg::CH_COLON) || (c == ucv_pkg::CH_AT)) begin
      ok = 1'b1;
    end else if (m == ucv_pkg::MODE_QUERY) begin
      ok = (c == ucv_pkg::CH_SLASH) || (c == ucv_pkg::CH_QUEST);
    end else if (m == ucv_pkg::MODE_SEGMENT) begin
      ok = 1'b0;
    end else begin
      ok = (c == ucv_pkg::CH_SLASH);
    end
    return ok;
  endfunction

  function automatic logic octet_ok(input logic [2:0] n, input logic [9:0] v,
                                    input logic lz);
    return (n != 3'd0) && (v <= ucv_pkg::OctetMax) &&
           !((n == ucv_pkg::OctetMaxDigits) && lz);
  endfunction

  // configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ucv_pkg::REG_MODE);
  assign prdata = (paddr[2] == ucv_pkg::REG_MODE) ?
                  {{(ucv_pkg::DataWidth-4){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ucv_pkg::MODE_SEGMENT;
    end else if (cfg_wr) begin
      mode_q <= pwdata[3:0];
    end
  end

  // the input register drains unless a last byte meets a blocked result
  assign s1_adv     = !s1_last_q || !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_char_q    <= char_code_i;
      s1_last_q    <= last_i;
      s1_no_char_q <= no_char_i;
    end
  end

  // per-byte grammar check and end-of-string verdict
  always_comb begin
    logic [7:0] c;
    logic [9:0] times_ten;
    c         = s1_char_q;
    times_ten = {value_q[6:0], 3'b000} + {value_q[8:0], 1'b0};
    esc_d      = esc_q;
    start_d    = start_q;
    failed_d   = failed_q;
    dots_d     = dots_q;
    digits_d   = digits_q;
    value_d    = value_q;
    lzero_d    = lzero_q;
    accepted_d = 1'b0;

    if (!s1_no_char_q) begin
      priority if (c == ucv_pkg::CH_NUL) begin
        failed_d = 1'b1;
      end else if (mode_q <= ucv_pkg::MODE_USERINFO) begin
        if (esc_q != 2'd0) begin
          if (!ucv_pkg::is_hex(c)) failed_d = 1'b1;
          esc_d = esc_q - 2'd1;
        end else if (c == ucv_pkg::CH_PERCENT) begin
          esc_d = ucv_pkg::EscDigits;
        end else if (!text_ok(c, mode_q)) begin
          failed_d = 1'b1;
        end
        if (start_q) begin
          if (((mode_q == ucv_pkg::MODE_ABSOLUTE) || (mode_q == ucv_pkg::MODE_ABEMPTY)) &&
              (c != ucv_pkg::CH_SLASH)) failed_d = 1'b1;
          if ((mode_q == ucv_pkg::MODE_ROOTLESS) && (c == ucv_pkg::CH_SLASH))
            failed_d = 1'b1;
        end
      end else if (mode_q == ucv_pkg::MODE_SCHEME) begin
        if (start_q ? !ucv_pkg::is_alpha(c)
                    : !(ucv_pkg::is_alpha(c) || ucv_pkg::is_digit(c) ||
                        (c == ucv_pkg::CH_PLUS) || (c == ucv_pkg::CH_MINUS) ||
                        (c == ucv_pkg::CH_DOT))) failed_d = 1'b1;
      end else if (mode_q == ucv_pkg::MODE_IPV4) begin
        if (ucv_pkg::is_digit(c)) begin
          if (digits_q >= ucv_pkg::OctetMaxDigits) begin
            failed_d = 1'b1;
          end else begin
            if ((digits_q == 3'd0) && (c == ucv_pkg::CH_ZERO)) lzero_d = 1'b1;
            value_d  = times_ten + {6'd0, c[3:0]};
            digits_d = digits_q + 3'd1;
          end
        end else if (c == ucv_pkg::CH_DOT) begin
          if (!octet_ok(digits_q, value_q, lzero_q) || (dots_q >= ucv_pkg::Ipv4Dots))
            failed_d = 1'b1;
          else
            dots_d = dots_q + 3'd1;
          digits_d = 3'd0;
          value_d  = 10'd0;
          lzero_d  = 1'b0;
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        failed_d = 1'b1;
      end
      start_d = 1'b0;
    end

    if (s1_last_q) begin
      priority if (failed_d || (esc_d != 2'd0) || (mode_q > ucv_pkg::MODE_IPV4)) begin
        accepted_d = 1'b0;
      end else if (mode_q == ucv_pkg::MODE_IPV4) begin
        accepted_d = (dots_d == ucv_pkg::Ipv4Dots) && octet_ok(digits_d, value_d, lzero_d);
      end else if (start_d && ((mode_q == ucv_pkg::MODE_ABSOLUTE) ||
                               (mode_q == ucv_pkg::MODE_ROOTLESS) ||
                               (mode_q == ucv_pkg::MODE_SCHEME))) begin
        accepted_d = 1'b0;
      end else begin
        accepted_d = 1'b1;
      end
      // string done: back to the idle string state
      esc_d    = 2'd0;
      start_d  = 1'b1;
      failed_d = 1'b0;
      dots_d   = 3'd0;
      digits_d = 3'd0;
      value_d  = 10'd0;
      lzero_d  = 1'b0;
    end
  end

  // string state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= 2'd0;
      start_q  <= 1'b1;
      failed_q <= 1'b0;
      dots_q   <= 3'd0;
      digits_q <= 3'd0;
      value_q  <= 10'd0;
      lzero_q  <= 1'b0;
    end else if (proc) begin
      esc_q    <= esc_d;
      start_q  <= start_d;
      failed_q <= failed_d;
      dots_q   <= dots_d;
      digits_q <= digits_d;
      value_q  <= value_d;
      lzero_q  <= lzero_d;
    end
  end

  // result register
  assign out_valid_d = (out_valid_q && out_stall_i) || (proc && s1_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && s1_last_q) begin
      accepted_q <= accepted_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

`ifndef SYNTHESIS
  // a finished string leaves the string state cleared
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_last_q |=> start_q && !failed_q && (esc_q == 2'd0) && (dots_q == 3'd0))
    else $error("string state not cleared after last byte");

  // a pending result is never overwritten by the next string end
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && s1_valid_q && s1_last_q |-> in_stall_o)
    else $error("pending result would be overwritten");

  // a new result only follows a processed last byte
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc && s1_last_q))
    else $error("result appeared without a last byte");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams URI component strings into the validator at most one byte per transfer,
// under every mode code, and compares each verdict with a local predictor
// of the component grammar. Both sides idle at random; the config port
// switches modes between strings and once in the middle of a string.
// ----------------------------------------------------------------------------
module tb_top;
  import ucv_pkg::*;

  typedef logic [7:0] byte_t;

  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxReports  = 10;
  // highest code the mode register can hold, unused by the grammar
  localparam logic [3:0]  ModeTop     = 4'hF;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrWidth-1:0] paddr       = '0;
  logic [DataWidth-1:0] pwdata      = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           char_code_i = '0;
  logic                 last_i      = 1'b0;
  logic                 no_char_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 accepted_o;

  uri_component_validator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .last_i     (last_i),
    .no_char_i  (no_char_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .accepted_o (accepted_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state for the string in progress
  logic [3:0] cur_mode;
  logic [1:0] esc_owed;
  logic       fresh;
  logic       broken;
  logic [2:0] dot_cnt;
  logic [2:0] oct_digits;
  logic [9:0] oct_val;
  logic       oct_zero;

  logic   verdicts[$];
  byte_t  text_q[$];
  bit     calm       = 1'b0;
  bit     hold_req   = 1'b0;
  int     fail_cnt   = 0;
  int     items_sent = 0;
  int     strings_done = 0;
  int     accepts_seen = 0;
  int     rejects_seen = 0;
  int     quiet_cycles = 0;
  logic [15:0] modes_used = '0;

  function automatic void report_fail(string what);
    fail_cnt++;
    if (fail_cnt <= MaxReports) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // append one byte to the string under construction
  function automatic void add_byte(byte_t c);
    text_q.insert(text_q.size(), c);
  endfunction

  // ascii classes
  function automatic bit chr_digit(byte_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit chr_alpha(byte_t c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit chr_hex(byte_t c);
    return chr_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic bit chr_unres(byte_t c);
    return chr_alpha(c) || chr_digit(c) || c == "-" || c == "." || c == "_" || c == "~";
  endfunction

  function automatic bit chr_subdelim(byte_t c);
    return c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
           c == "*" || c == "+" || c == "," || c == ";" || c == "=";
  endfunction

  // plain byte allowed by the text grammars
  function automatic bit text_byte_allowed(byte_t c, logic [3:0] m);
    if (chr_unres(c) || chr_subdelim(c)) return 1'b1;
    if (m == MODE_USERINFO) return c == ":";
    if (c == ":" || c == "@") return 1'b1;
    if (m == MODE_QUERY) return c == "/" || c == "?";
    if (m == MODE_SEGMENT) return 1'b0;
    return c == "/";
  endfunction

  function automatic void restart_string();
    esc_owed   = '0;
    fresh      = 1'b1;
    broken     = 1'b0;
    dot_cnt    = '0;
    oct_digits = '0;
    oct_val    = '0;
    oct_zero   = 1'b0;
  endfunction

  function automatic bit octet_good();
    if (oct_digits == 0 || oct_val > OctetMax) return 1'b0;
    return !(oct_digits == OctetMaxDigits && oct_zero);
  endfunction

  // state update for one byte under the mode in force now
  function automatic void absorb_byte(byte_t c);
    if (c == CH_NUL) begin
      broken = 1'b1;
    end else if (cur_mode <= MODE_USERINFO) begin
      if (esc_owed != 0) begin
        if (!chr_hex(c)) broken = 1'b1;
        esc_owed = esc_owed - 2'd1;
      end else if (c == "%") begin
        esc_owed = EscDigits;
      end else if (!text_byte_allowed(c, cur_mode)) begin
        broken = 1'b1;
      end
      if (fresh) begin
        if ((cur_mode == MODE_ABSOLUTE || cur_mode == MODE_ABEMPTY) && c != "/") broken = 1'b1;
        if (cur_mode == MODE_ROOTLESS && c == "/") broken = 1'b1;
      end
    end else if (cur_mode == MODE_SCHEME) begin
      if (fresh ? !chr_alpha(c)
                : !(chr_alpha(c) || chr_digit(c) || c == "+" || c == "-" || c == "."))
        broken = 1'b1;
    end else if (cur_mode == MODE_IPV4) begin
      if (chr_digit(c)) begin
        if (oct_digits >= OctetMaxDigits) begin
          broken = 1'b1;
        end else begin
          if (oct_digits == 0 && c == "0") oct_zero = 1'b1;
          oct_val    = 10'(oct_val * 10 + (c - "0"));
          oct_digits = oct_digits + 3'd1;
        end
      end else if (c == ".") begin
        if (!octet_good() || dot_cnt >= Ipv4Dots) broken = 1'b1;
        else dot_cnt = dot_cnt + 3'd1;
        oct_digits = '0;
        oct_val    = '0;
        oct_zero   = 1'b0;
      end else begin
        broken = 1'b1;
      end
    end else begin
      broken = 1'b1;
    end
    fresh = 1'b0;
  endfunction

  function automatic logic string_verdict();
    if (broken || esc_owed != 0 || cur_mode > MODE_IPV4) return 1'b0;
    if (cur_mode == MODE_IPV4) return dot_cnt == Ipv4Dots && octet_good();
    if (fresh && (cur_mode inside {MODE_ABSOLUTE, MODE_ROOTLESS, MODE_SCHEME})) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_item(byte_t c, logic lst, logic nc);
    if (!nc) absorb_byte(c);
    if (lst) begin
      verdicts.insert(verdicts.size(), string_verdict());
      restart_string();
    end
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin : result_check
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts.size() == 0) begin
        report_fail($sformatf("result accepted=%0b with no string pending", accepted_o));
      end else begin
        want = verdicts.pop_front();
        strings_done++;
        if (accepted_o !== want)
          report_fail($sformatf("accepted expected %0b got %0b", want, accepted_o));
        else if (want) accepts_seen++;
        else rejects_seen++;
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d cycles with no transfer", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side stall: random, off when calm, long hold-off on request
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 14);
      end
    end
  end

  // one config access: setup then access phase
  task automatic apb_access(input logic wr, input logic [AddrWidth-1:0] a,
                            input logic [DataWidth-1:0] d,
                            output logic [DataWidth-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid and wait until every verdict is in and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdicts.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_mode(input logic [3:0] m);
    logic [AddrWidth-1:0] a;
    logic [DataWidth-1:0] d;
    logic [DataWidth-1:0] rd;
    settle();
    a = AddrWidth'({REG_MODE, 2'b00});
    d = $urandom();
    d[3:0] = m;
    apb_access(1'b1, a, d, rd);
    apb_access(1'b0, a, '0, rd);
    if (rd[3:0] !== m) report_fail($sformatf("mode readback expected %0d got %0d", m, rd[3:0]));
    cur_mode = m;
    modes_used[m] = 1'b1;
  endtask

  // one input transfer, with a random gap ahead of it
  task automatic send_item(input byte_t c, input logic lst, input logic nc);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_i      <= lst;
    no_char_i   <= nc;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_item(c, lst, nc);
    if (lst || !nc) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_empty();
    send_item(byte_t'($urandom), 1'b1, 1'b1);
  endtask

  // send the queued string; sometimes close it with a byteless last transfer
  task automatic send_text();
    bit split_end;
    split_end = (text_q.size() == 0) || ($urandom_range(7) == 0);
    for (int i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(24) == 0) send_item(byte_t'($urandom), 1'b0, 1'b1);
      send_item(text_q[i], !split_end && (i == text_q.size() - 1), 1'b0);
    end
    if (split_end) send_empty();
    text_q.delete();
  endtask

  // string builders
  function automatic void load_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic byte_t pick_from(string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic byte_t alpha_char();
    return pick_from("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz");
  endfunction

  function automatic byte_t text_char(logic [3:0] m);
    case ($urandom_range(6))
      0, 1: return alpha_char();
      2: return pick_from("0123456789");
      3: return pick_from("-._~");
      4: return pick_from("!$&'()*+,;=");
      5: return (m == MODE_USERINFO) ? byte_t'(":") : pick_from(":@");
      default: begin
        if (m == MODE_QUERY) return pick_from("/?");
        if (m == MODE_SEGMENT || m == MODE_USERINFO) return alpha_char();
        return "/";
      end
    endcase
  endfunction

  function automatic void build_text(logic [3:0] m);
    int len;
    len = $urandom_range(8);
    if (m == MODE_ROOTLESS && len == 0) len = 1;
    if (m == MODE_ABSOLUTE || (m == MODE_ABEMPTY && len != 0)) add_byte("/");
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) begin
        add_byte("%");
        add_byte(pick_from("0123456789abcdefABCDEF"));
        add_byte(pick_from("0123456789abcdefABCDEF"));
      end else begin
        add_byte(text_char(m));
      end
    end
    if (m == MODE_ROOTLESS && text_q[0] == "/") text_q[0] = alpha_char();
    // broken variants: one stray byte, or an escape left open at the end
    if ($urandom_range(5) == 0 && text_q.size() != 0) begin
      text_q[$urandom_range(text_q.size() - 1)] = byte_t'($urandom);
    end else if ($urandom_range(9) == 0) begin
      add_byte("%");
      if ($urandom_range(1)) add_byte(pick_from("0123456789abcdef"));
    end
  endfunction

  function automatic void build_scheme();
    add_byte(alpha_char());
    repeat ($urandom_range(6)) begin
      if ($urandom_range(3) == 0) add_byte(pick_from("+-.0123456789"));
      else add_byte(alpha_char());
    end
  endfunction

  function automatic void push_decimal(int v, int width);
    byte_t digs[$];
    do begin
      digs.push_front(byte_t'("0" + v % 10));
      v = v / 10;
    end while (v != 0);
    while (digs.size() < width) digs.push_front("0");
    foreach (digs[i]) add_byte(digs[i]);
  endfunction

  // dotted quad, mostly well formed, with bad octets and wrong counts mixed in
  function automatic void build_ipv4();
    int n_oct;
    int style;
    n_oct = 4;
    case ($urandom_range(9))
      0: n_oct = 3;
      1: n_oct = 5;
      default: ;
    endcase
    for (int k = 0; k < n_oct; k++) begin
      if (k != 0) add_byte(".");
      style = $urandom_range(19);
      if (style < 13) push_decimal($urandom_range(255), 0);
      else if (style < 15) push_decimal($urandom_range(99), 3);
      else if (style < 17) push_decimal($urandom_range(9), 2);
      else if (style < 19) push_decimal($urandom_range(999, 256), 0);
      else if ($urandom_range(1)) push_decimal($urandom_range(9999, 1000), 0);
    end
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(1)) add_byte(byte_t'($urandom_range(126, 32)));
      else add_byte(byte_t'($urandom));
    end
  endfunction

  function automatic void build_string(logic [3:0] m);
    if ($urandom_range(4) == 0) build_noise();
    else if (m == MODE_SCHEME) build_scheme();
    else if (m == MODE_IPV4) build_ipv4();
    else if (m <= MODE_USERINFO) build_text(m);
    else build_text(MODE_PATH);
  endfunction

  // empty string under the reset mode, every grammar and the top mode code
  task automatic test_empty_strings();
    send_empty();
    for (int i = 0; i <= MODE_IPV4; i++) begin
      set_mode(4'(i));
      send_empty();
    end
    set_mode(ModeTop);
    send_empty();
  endtask

  // escapes cut short, nul, high byte, byteless item that is not last
  task automatic test_escapes_and_odd_bytes();
    set_mode(MODE_PATH);
    load_text("%4/");
    send_text();
    load_text("%a");
    send_text();
    add_byte(CH_NUL);
    send_text();
    add_byte(8'hFF);
    send_text();
    send_item(byte_t'($urandom), 1'b0, 1'b1);
    load_text("~");
    send_text();
  endtask

  // mode switched between two bytes of one string
  task automatic test_mid_string_mode();
    set_mode(MODE_QUERY);
    send_item(CH_SLASH, 1'b0, 1'b0);
    set_mode(MODE_SEGMENT);
    send_item("a", 1'b1, 1'b0);
  endtask

  task automatic test_ipv4_edges();
    set_mode(MODE_IPV4);
    load_text("0.09.255.1");
    send_text();
  endtask

  // every mode code in turn, fewer strings for the unused codes
  task automatic test_random_strings();
    int goal;
    for (int p = 0; p <= ModeTop; p++) begin
      set_mode(4'(p));
      goal = items_sent + ((p <= MODE_IPV4) ? 100 : 20);
      while (items_sent < goal) begin
        build_string(cur_mode);
        send_text();
      end
    end
  endtask

  // no idling on either side
  task automatic test_full_rate(input int n_items);
    int goal;
    set_mode(4'($urandom_range(MODE_IPV4)));
    calm = 1'b1;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      build_string(cur_mode);
      send_text();
    end
    calm = 1'b0;
  endtask

  // receiver holds off while short strings keep coming, so the block fills up
  task automatic test_backpressure(input int n_items);
    int goal;
    set_mode(MODE_SCHEME);
    calm = 1'b1;
    hold_req = 1'b1;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      if ($urandom_range(1)) add_byte(alpha_char());
      else build_string(cur_mode);
      send_text();
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    cur_mode = MODE_SEGMENT;
    modes_used[MODE_SEGMENT] = 1'b1;
    restart_string();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_strings();
    test_escapes_and_odd_bytes();
    test_mid_string_mode();
    test_ipv4_edges();
    test_random_strings();
    test_full_rate(120);
    test_backpressure(100);

    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d strings from %0d transfers across %0d of 16 mode codes",
             strings_done, items_sent, $countones(modes_used));
    $display("verdicts matched: %0d accepted, %0d rejected; %0d failures",
             accepts_seen, rejects_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
